/* hdl/nixie_digit_frame_serializer_defines.svh */
// Assertion macros shared by the serializer RTL.
// No dependencies; included by the modules that carry checks.
`ifndef NIXIE_DIGIT_FRAME_SERIALIZER_DEFINES_SVH
`define NIXIE_DIGIT_FRAME_SERIALIZER_DEFINES_SVH

`ifndef ASSERT_OFF
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif

`endif

/* hdl/ndfs_pkg.sv */
// Shared types, constants and the tube-to-line table of the serializer.
// No dependencies.
package ndfs_pkg;

    localparam int LINE_COUNT = 60;
    localparam int NUM_TUBES  = 6;
    localparam int NUM_DIGITS = 10;
    localparam int DIGIT_W    = 4;
    localparam int MODE_W     = 3;
    localparam int LINE_W     = $clog2(LINE_COUNT);
    localparam int CNT_W      = $clog2(LINE_COUNT + 1);
    localparam int PHASE_W    = 3;

    localparam logic [CNT_W-1:0]   LATCH_POS = CNT_W'(LINE_COUNT);
    localparam logic [PHASE_W-1:0] PHASE_MAX = PHASE_W'(3);
    localparam logic [DIGIT_W-1:0] DIGIT_MAX = DIGIT_W'(NUM_DIGITS - 1);

    typedef enum logic [MODE_W-1:0] {
        MODE_ALL  = 3'd0,
        MODE_SEC  = 3'd1,
        MODE_MIN  = 3'd2,
        MODE_HOUR = 3'd3
    } t_mode;

    typedef logic [NUM_TUBES-1:0][DIGIT_W-1:0] t_digit_vec;

    typedef struct packed {
        logic                  load;
        logic [LINE_COUNT-1:0] frame;
    } t_shift_ctrl;

    typedef struct packed {
        logic busy;
    } t_shift_status;

    // Driver line of each digit, one row per tube (tube one first).
    localparam logic [LINE_W-1:0] TUBE_MAP [NUM_TUBES][NUM_DIGITS] = '{
        '{6'd9,  6'd15, 6'd14, 6'd13, 6'd12, 6'd11, 6'd10, 6'd6,  6'd7,  6'd8},
        '{6'd16, 6'd0,  6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd19, 6'd18, 6'd17},
        '{6'd29, 6'd35, 6'd34, 6'd33, 6'd32, 6'd31, 6'd30, 6'd26, 6'd27, 6'd28},
        '{6'd36, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25, 6'd39, 6'd38, 6'd37},
        '{6'd49, 6'd55, 6'd54, 6'd53, 6'd52, 6'd51, 6'd50, 6'd46, 6'd47, 6'd48},
        '{6'd56, 6'd40, 6'd41, 6'd42, 6'd43, 6'd44, 6'd45, 6'd59, 6'd58, 6'd57}
    };

endpackage

/* hdl/ndfs_channels.sv */
// Valid/ready channel interfaces for the digit word and the line word.
// Depends on ndfs_pkg.
interface ndfs_in_if import ndfs_pkg::*;;
    logic               valid;
    logic               ready;
    logic [DIGIT_W-1:0] digit_sec_lo;
    logic [DIGIT_W-1:0] digit_sec_hi;
    logic [DIGIT_W-1:0] digit_min_lo;
    logic [DIGIT_W-1:0] digit_min_hi;
    logic [DIGIT_W-1:0] digit_hour_lo;
    logic [DIGIT_W-1:0] digit_hour_hi;
    logic [MODE_W-1:0]  display_mode;

    modport source (
        output valid, digit_sec_lo, digit_sec_hi, digit_min_lo, digit_min_hi,
               digit_hour_lo, digit_hour_hi, display_mode,
        input  ready
    );
    modport sink (
        input  valid, digit_sec_lo, digit_sec_hi, digit_min_lo, digit_min_hi,
               digit_hour_lo, digit_hour_hi, display_mode,
        output ready
    );
endinterface

interface ndfs_out_if;
    logic valid;
    logic ready;
    logic line_level;
    logic latch_pulse;
    logic frame_end;

    modport source (output valid, line_level, latch_pulse, frame_end, input ready);
    modport sink   (input valid, line_level, latch_pulse, frame_end, output ready);
endinterface

/* hdl/nixie_digit_frame_serializer.sv */
// Serializer top level: takes six digits and a mode, returns 60 line bits and a latch.
// An accepted word yields 61 output words, the first in the cycle after acceptance,
// one per cycle while the sink is ready; the next input word is taken only after
// the latch word leaves, as the busy 60-bit line shifter holds the input until
// then. Synchronous active-low reset clears the frame phase, the line counter and
// the busy flag; no output word is valid after reset.
module nixie_digit_frame_serializer import ndfs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ndfs_in_if.sink   i_in,
    ndfs_out_if.source o_out
);

    t_shift_ctrl   ctrl;
    t_shift_status status;
    t_digit_vec    digits;
    logic          in_fire;

    assign i_in.ready = !status.busy;
    assign in_fire    = i_in.valid && i_in.ready;

    assign digits = {i_in.digit_hour_hi, i_in.digit_hour_lo,
                     i_in.digit_min_hi,  i_in.digit_min_lo,
                     i_in.digit_sec_hi,  i_in.digit_sec_lo};

    ndfs_frame_build u_build (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (in_fire),
        .i_digits (digits),
        .i_mode   (i_in.display_mode),
        .o_ctrl   (ctrl)
    );

    ndfs_line_shifter u_shift (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (ctrl),
        .o_status (status),
        .o_out    (o_out)
    );

endmodule

/* hdl/ndfs_frame_build.sv */
// Frame builder: phase counter, tube enables and digit-to-line decode.
// Depends on ndfs_pkg.
module ndfs_frame_build import ndfs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  t_digit_vec        i_digits,
    input  logic [MODE_W-1:0] i_mode,
    output t_shift_ctrl       o_ctrl
);

    logic [PHASE_W-1:0]    r_phase;
    logic [PHASE_W-1:0]    n_phase;
    logic [NUM_TUBES-1:0]  tube_en;
    logic [LINE_COUNT-1:0] frame;

    always_comb begin
        tube_en = '0;
        if (t_mode'(i_mode) == MODE_ALL || r_phase == '0) begin
            tube_en = '1;
        end else begin
            case (t_mode'(i_mode))
                MODE_SEC:  tube_en = 6'b000011;
                MODE_MIN:  tube_en = 6'b001100;
                MODE_HOUR: tube_en = 6'b110000;
                default:   tube_en = '0;
            endcase
        end
    end

    // Pull the selected cathode line low; digits above nine stay dark.
    always_comb begin
        frame = '1;
        for (int t = 0; t < NUM_TUBES; t++) begin
            if (tube_en[t] && i_digits[t] <= DIGIT_MAX) begin
                frame[TUBE_MAP[t][i_digits[t]]] = 1'b0;
            end
        end
    end

    assign n_phase = (r_phase > PHASE_MAX) ? '0 : r_phase + PHASE_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (i_take) begin
            r_phase <= n_phase;
        end
    end

    assign o_ctrl.load  = i_take;
    assign o_ctrl.frame = frame;

endmodule

/* hdl/ndfs_line_shifter.sv */
// Line shifter: holds one frame and sends it one line bit per word, then the latch.
// Depends on ndfs_pkg and the channel interfaces.
`include "nixie_digit_frame_serializer_defines.svh"

module ndfs_line_shifter import ndfs_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_shift_ctrl   i_ctrl,
    output t_shift_status o_status,
    ndfs_out_if.source    o_out
);

    logic                  r_busy;
    logic [CNT_W-1:0]      r_count;
    logic [LINE_COUNT-1:0] r_frame;
    logic                  out_fire;
    logic                  at_latch;

    assign out_fire = o_out.valid && o_out.ready;
    assign at_latch = (r_count == LATCH_POS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_count <= '0;
        end else if (i_ctrl.load) begin
            r_busy  <= 1'b1;
            r_count <= '0;
        end else if (out_fire) begin
            if (at_latch) begin
                r_busy  <= 1'b0;
                r_count <= '0;
            end else begin
                r_count <= r_count + CNT_W'(1);
            end
        end
    end

    // Advance one line per accepted word, line 0 first.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_frame <= i_ctrl.frame;
        end else if (out_fire) begin
            r_frame <= {1'b0, r_frame[LINE_COUNT-1:1]};
        end
    end

    assign o_status.busy    = r_busy;
    assign o_out.valid       = r_busy;
    assign o_out.line_level  = r_frame[0] && !at_latch;
    assign o_out.latch_pulse = at_latch;
    assign o_out.frame_end   = at_latch;

    `ASSERT_NEVER(a_load_while_busy, i_clk, i_rst_n, i_ctrl.load && r_busy,
        "frame loaded while a frame is still being sent")
    `ASSERT_CLK(a_load_starts, i_clk, i_rst_n,
        i_ctrl.load |=> (o_out.valid && !o_out.latch_pulse && r_count == '0),
        "loaded frame does not start at line 0")
    `ASSERT_CLK(a_latch_ends, i_clk, i_rst_n,
        (out_fire && o_out.latch_pulse) |=> !o_out.valid,
        "word sent after the latch word")
    `ASSERT_NEVER(a_count_range, i_clk, i_rst_n, r_count > LATCH_POS,
        "line counter past the latch position")

endmodule
